### src/cir_pkg.sv
// Shared constants and types for the contact impulse resolver.
package cir_pkg;

   // Restoring divider: one quotient bit per stage
   localparam int DIV_STEPS = 32;
   localparam int NUM_W     = 64;
   localparam int DVS_W     = 33;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [46:0] JMAX    = 47'h4000_0000_0000;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_SLOP     = 2'd0,
      CSR_FRACTION = 2'd1,
      CSR_IMMOVABLE = 2'd2
   } csr_index_type;

   // Clip a wide signed value to int32; top bit of the result flags clipping
   function automatic logic [32:0] sat32(input logic signed [49:0] v);
      logic [32:0] r;
      if (v > 50'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -50'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

### src/cir_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cir_div (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [cir_pkg::NUM_W-1:0]   num,
   input  logic [cir_pkg::DVS_W-1:0]   dvs,
   output logic [cir_pkg::DIV_STEPS-1:0] quo
);

   localparam int S = cir_pkg::DIV_STEPS;
   localparam int W = cir_pkg::DVS_W;

   logic [W-1:0] rem_ff [S];
   logic [S-1:0] low_ff [S];
   logic [S-1:0] quo_ff [S];
   logic [W-1:0] dvs_ff [S];

   logic [W-1:0] rem_in [S];
   logic [S-1:0] low_in [S];
   logic [S-1:0] quo_in [S];
   logic [W-1:0] dvs_in [S];

   // One compare and subtract per stage
   always_comb begin
      logic [W-1:0] r;
      logic         b;
      logic [W:0]   sh;
      for (int k = 0; k < S; k++) begin
         if (k == 0) begin
            r         = W'(num[cir_pkg::NUM_W-1:S]);
            b         = num[S-1];
            low_in[k] = {num[S-2:0], 1'b0};
            dvs_in[k] = dvs;
            quo_in[k] = '0;
         end else begin
            r         = rem_ff[k-1];
            b         = low_ff[k-1][S-1];
            low_in[k] = {low_ff[k-1][S-2:0], 1'b0};
            dvs_in[k] = dvs_ff[k-1];
            quo_in[k] = quo_ff[k-1];
         end
         sh = {r, b};
         if (sh >= {1'b0, dvs_in[k]}) begin
            rem_in[k] = W'(sh - {1'b0, dvs_in[k]});
            quo_in[k] = {quo_in[k][S-2:0], 1'b1};
         end else begin
            rem_in[k] = sh[W-1:0];
            quo_in[k] = {quo_in[k][S-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < S; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            dvs_ff[k] <= dvs_in[k];
         end
      end
   end

   assign quo = quo_ff[S-1];

endmodule

### src/contact_impulse_resolver.sv
// Contact pair resolver: positional correction and impulse, fully pipelined.
//
//  channel   ports                          carries
//  req       req_tvalid/tready/tdata/tuser  one contact pair (tuser: bodies_present)
//  rsp       rsp_tvalid/tready/tdata/tuser  pushes and impulse (tuser: flags)
//  csr       csr_we/index/wdata             slop, correction fraction, immovable mass
//
// One item per cycle while the pipe is not held; the 32-stage restoring dividers for
// the inverse-mass split and the reduced mass, plus nine arithmetic stages, set its depth.
// Reset clears the valid bits and loads the register defaults.
// All stages advance together; when the result is not taken the whole pipe holds.
module contact_impulse_resolver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // normal_x, normal_y, penetration, mass_a, mass_b, bounce_a, bounce_b,
   // vel_a_x, vel_a_y, vel_b_x, vel_b_y, zero fill
   input  logic [295:0] req_tdata,
   // bodies_present
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // push_a_x, push_a_y, push_b_x, push_b_y, impulse_x, impulse_y
   output logic [191:0] rsp_tdata,
   // resolved, saturated
   output logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   localparam int S = cir_pkg::DIV_STEPS;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic [30:0]        pen;
      logic [31:0]        ma, mb;
      logic [16:0]        ba, bb;
      logic signed [31:0] vax, vay, vbx, vby;
      logic [1:0]         pres;
   } a_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               pres_nz, dyna, dynb, push_on;
      logic [30:0]        excess;
      logic [16:0]        frac, e;
      logic [31:0]        ma, mb, mea, meb;
      logic [32:0]        mab, mem;
      logic signed [32:0] dvx, dvy;
   } b_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               pres_nz, dyna, dynb, push_on;
      logic [47:0]        mprod_p;
      logic [16:0]        e;
      logic [31:0]        ma, mb;
      logic [32:0]        mab, mem;
      logic [63:0]        mprod;
      logic signed [48:0] px, py;
   } c_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               pres_nz, dyna, dynb, push_on;
      logic [30:0]        mag;
      logic [16:0]        e;
      logic [31:0]        ma, mb;
      logic [32:0]        mab, mem;
      logic [63:0]        mprod;
      logic signed [49:0] van;
   } d_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               pres_nz, dyna, dynb, push_on, imp_on;
      logic [30:0]        mag;
      logic [36:0]        u;
   } pay_type;

   typedef struct packed {
      pay_type     p;
      logic [63:0] num_a, num_b, mprod;
      logic [32:0] mab, mem;
   } e_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               push_on_a, push_on_b, imp_on, pres_nz;
      logic [47:0]        ppax, ppay, ppbx, ppby;
      logic [63:0]        jl;
      logic [36:0]        jh;
   } f_type;

   typedef struct packed {
      logic signed [15:0] nx, ny;
      logic               push_on_a, push_on_b, imp_on, pres_nz;
      logic [32:0]        max, may, mbx, mby;
      logic [46:0]        j;
   } g_type;

   typedef struct packed {
      logic signed [49:0] pax, pay, pbx, pby;
      logic               nsx, nsy, imp_on, pres_nz;
      logic [47:0]        jmx, jmy;
   } h_type;

   // Configuration registers
   logic [30:0] slop_ff;
   logic [16:0] frac_ff;
   logic [31:0] imm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slop_ff <= 31'd655;
         frac_ff <= 17'd52429;
         imm_ff  <= 32'hFFFF_FFFF;
      end else if (csr_we) begin
         case (csr_index)
            cir_pkg::CSR_SLOP:      slop_ff <= csr_wdata[30:0];
            cir_pkg::CSR_FRACTION:  frac_ff <= csr_wdata[16:0];
            cir_pkg::CSR_IMMOVABLE: imm_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Whole pipe advances when the output register is free or being taken
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   a_type   a_ff, a_in;
   b_type   b_ff, b_in;
   c_type   c_ff, c_in;
   d_type   d_ff, d_in;
   e_type   e_ff, e_in;
   pay_type pay_ff [S];
   f_type   f_ff, f_in;
   g_type   g_ff, g_in;
   h_type   h_ff, h_in;
   logic [191:0] odata_in;
   logic [1:0]   ouser_in;
   logic         va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff;
   logic [S-1:0] vq_ff;
   logic [31:0]  q_a, q_b, q_m;

   // Unpack the item
   always_comb begin
      a_in.nx   = req_tdata[15:0];
      a_in.ny   = req_tdata[31:16];
      a_in.pen  = req_tdata[62:32];
      a_in.ma   = req_tdata[94:63];
      a_in.mb   = req_tdata[126:95];
      a_in.ba   = req_tdata[143:127];
      a_in.bb   = req_tdata[160:144];
      a_in.vax  = req_tdata[192:161];
      a_in.vay  = req_tdata[224:193];
      a_in.vbx  = req_tdata[256:225];
      a_in.vby  = req_tdata[288:257];
      a_in.pres = req_tuser;
   end

   // Body classes, clamps, effective masses, relative velocity
   always_comb begin
      logic        hasa, hasb;
      logic [16:0] bae, bbe;
      logic [31:0] imm;
      logic signed [31:0] vax, vay, vbx, vby;
      hasa = a_ff.pres[0];
      hasb = a_ff.pres[1];
      imm  = (imm_ff == '0) ? 32'd1 : imm_ff;
      bae  = hasa ? a_ff.ba : '0;
      bbe  = hasb ? a_ff.bb : '0;
      if (bae > cir_pkg::ONE_Q16) bae = cir_pkg::ONE_Q16;
      if (bbe > cir_pkg::ONE_Q16) bbe = cir_pkg::ONE_Q16;
      vax  = hasa ? a_ff.vax : '0;
      vay  = hasa ? a_ff.vay : '0;
      vbx  = hasb ? a_ff.vbx : '0;
      vby  = hasb ? a_ff.vby : '0;
      b_in.nx      = a_ff.nx;
      b_in.ny      = a_ff.ny;
      b_in.pres_nz = a_ff.pres != 2'd0;
      b_in.dyna    = hasa && (a_ff.ma != '0);
      b_in.dynb    = hasb && (a_ff.mb != '0);
      b_in.push_on = b_in.pres_nz && (a_ff.pen > slop_ff) && (b_in.dyna || b_in.dynb);
      b_in.excess  = a_ff.pen - slop_ff;
      b_in.frac    = (frac_ff > cir_pkg::ONE_Q16) ? cir_pkg::ONE_Q16 : frac_ff;
      b_in.e       = (bae > bbe) ? bae : bbe;
      b_in.ma      = a_ff.ma;
      b_in.mb      = a_ff.mb;
      b_in.mea     = b_in.dyna ? a_ff.ma : imm;
      b_in.meb     = b_in.dynb ? a_ff.mb : imm;
      b_in.mab     = 33'(a_ff.ma) + 33'(a_ff.mb);
      b_in.mem     = 33'(b_in.mea) + 33'(b_in.meb);
      b_in.dvx     = 33'(vbx) - 33'(vax);
      b_in.dvy     = 33'(vby) - 33'(vay);
   end

   // Products: correction magnitude, normal speed terms, mass product
   always_comb begin
      c_in.nx      = b_ff.nx;
      c_in.ny      = b_ff.ny;
      c_in.pres_nz = b_ff.pres_nz;
      c_in.dyna    = b_ff.dyna;
      c_in.dynb    = b_ff.dynb;
      c_in.push_on = b_ff.push_on;
      c_in.mprod_p = 48'(b_ff.excess) * 48'(b_ff.frac);
      c_in.e       = b_ff.e;
      c_in.ma      = b_ff.ma;
      c_in.mb      = b_ff.mb;
      c_in.mab     = b_ff.mab;
      c_in.mem     = b_ff.mem;
      c_in.mprod   = 64'(b_ff.mea) * 64'(b_ff.meb);
      c_in.px      = 49'(b_ff.dvx) * 49'(b_ff.nx);
      c_in.py      = 49'(b_ff.dvy) * 49'(b_ff.ny);
   end

   // Scale magnitude, sum the normal velocity
   always_comb begin
      d_in.nx      = c_ff.nx;
      d_in.ny      = c_ff.ny;
      d_in.pres_nz = c_ff.pres_nz;
      d_in.dyna    = c_ff.dyna;
      d_in.dynb    = c_ff.dynb;
      d_in.push_on = c_ff.push_on;
      d_in.mag     = c_ff.mprod_p[46:16];
      d_in.e       = c_ff.e;
      d_in.ma      = c_ff.ma;
      d_in.mb      = c_ff.mb;
      d_in.mab     = c_ff.mab;
      d_in.mem     = c_ff.mem;
      d_in.mprod   = c_ff.mprod;
      d_in.van     = 50'(c_ff.px) + 50'(c_ff.py);
   end

   // Dividends for the mass split; closing speed times restitution
   always_comb begin
      logic signed [49:0] nvan;
      logic [35:0]        vn;
      logic [53:0]        up;
      nvan = -d_ff.van;
      vn   = nvan[49:14];
      up   = 54'(vn) * 54'(18'(cir_pkg::ONE_Q16) + 18'(d_ff.e));
      e_in.p.nx      = d_ff.nx;
      e_in.p.ny      = d_ff.ny;
      e_in.p.pres_nz = d_ff.pres_nz;
      e_in.p.dyna    = d_ff.dyna;
      e_in.p.dynb    = d_ff.dynb;
      e_in.p.push_on = d_ff.push_on;
      e_in.p.imp_on  = d_ff.pres_nz && d_ff.van[49];
      e_in.p.mag     = d_ff.mag;
      e_in.p.u       = up[52:16];
      e_in.num_a     = 64'(d_ff.mag) * 64'(d_ff.mb);
      e_in.num_b     = 64'(d_ff.mag) * 64'(d_ff.ma);
      e_in.mprod     = d_ff.mprod;
      e_in.mab       = d_ff.mab;
      e_in.mem       = d_ff.mem;
   end

   cir_div u_div_a (.clock(clock), .adv(adv), .num(e_ff.num_a), .dvs(e_ff.mab), .quo(q_a));
   cir_div u_div_b (.clock(clock), .adv(adv), .num(e_ff.num_b), .dvs(e_ff.mab), .quo(q_b));
   cir_div u_div_m (.clock(clock), .adv(adv), .num(e_ff.mprod), .dvs(e_ff.mem), .quo(q_m));

   // Push shares, normal scaling, impulse partial products
   always_comb begin
      pay_type     p;
      logic [31:0] sa, sb;
      logic [15:0] axn, ayn;
      p   = pay_ff[S-1];
      sa  = (p.dyna && p.dynb) ? q_a : 32'(p.mag);
      sb  = (p.dyna && p.dynb) ? q_b : 32'(p.mag);
      axn = p.nx[15] ? 16'(-p.nx) : 16'(p.nx);
      ayn = p.ny[15] ? 16'(-p.ny) : 16'(p.ny);
      f_in.nx        = p.nx;
      f_in.ny        = p.ny;
      f_in.push_on_a = p.push_on && p.dyna;
      f_in.push_on_b = p.push_on && p.dynb;
      f_in.imp_on    = p.imp_on;
      f_in.pres_nz   = p.pres_nz;
      f_in.ppax      = 48'(axn) * 48'(sa);
      f_in.ppay      = 48'(ayn) * 48'(sa);
      f_in.ppbx      = 48'(axn) * 48'(sb);
      f_in.ppby      = 48'(ayn) * 48'(sb);
      f_in.jl        = 64'(p.u[31:0]) * 64'(q_m);
      f_in.jh        = 37'(p.u[36:32]) * 37'(q_m);
   end

   // Impulse magnitude with its limit, push magnitudes
   always_comb begin
      logic [68:0] jf;
      jf = (69'(f_ff.jh) << 32) + 69'(f_ff.jl);
      g_in.nx        = f_ff.nx;
      g_in.ny        = f_ff.ny;
      g_in.push_on_a = f_ff.push_on_a;
      g_in.push_on_b = f_ff.push_on_b;
      g_in.imp_on    = f_ff.imp_on;
      g_in.pres_nz   = f_ff.pres_nz;
      g_in.max       = f_ff.ppax[46:14];
      g_in.may       = f_ff.ppay[46:14];
      g_in.mbx       = f_ff.ppbx[46:14];
      g_in.mby       = f_ff.ppby[46:14];
      g_in.j         = (jf[68:16] > 53'(cir_pkg::JMAX)) ? cir_pkg::JMAX : jf[62:16];
   end

   // Impulse along the normal, signed pushes
   always_comb begin
      logic [15:0] axn, ayn;
      logic [63:0] jpx, jpy;
      logic signed [49:0] mx, my, nbx, nby;
      axn = g_ff.nx[15] ? 16'(-g_ff.nx) : 16'(g_ff.nx);
      ayn = g_ff.ny[15] ? 16'(-g_ff.ny) : 16'(g_ff.ny);
      jpx = 64'(axn) * 64'(g_ff.j);
      jpy = 64'(ayn) * 64'(g_ff.j);
      mx  = 50'(g_ff.max);
      my  = 50'(g_ff.may);
      nbx = 50'(g_ff.mbx);
      nby = 50'(g_ff.mby);
      h_in.pax = !g_ff.push_on_a ? '0 : (g_ff.nx[15] ? mx : -mx);
      h_in.pay = !g_ff.push_on_a ? '0 : (g_ff.ny[15] ? my : -my);
      h_in.pbx = !g_ff.push_on_b ? '0 : (g_ff.nx[15] ? -nbx : nbx);
      h_in.pby = !g_ff.push_on_b ? '0 : (g_ff.ny[15] ? -nby : nby);
      h_in.nsx     = g_ff.nx[15];
      h_in.nsy     = g_ff.ny[15];
      h_in.imp_on  = g_ff.imp_on;
      h_in.pres_nz = g_ff.pres_nz;
      h_in.jmx     = jpx[61:14];
      h_in.jmy     = jpy[61:14];
   end

   // Saturate and pack the result
   always_comb begin
      logic signed [49:0] jx, jy;
      logic [32:0] r0, r1, r2, r3, r4, r5;
      jx = !h_ff.imp_on ? '0 : (h_ff.nsx ? -50'(h_ff.jmx) : 50'(h_ff.jmx));
      jy = !h_ff.imp_on ? '0 : (h_ff.nsy ? -50'(h_ff.jmy) : 50'(h_ff.jmy));
      r0 = cir_pkg::sat32(h_ff.pax);
      r1 = cir_pkg::sat32(h_ff.pay);
      r2 = cir_pkg::sat32(h_ff.pbx);
      r3 = cir_pkg::sat32(h_ff.pby);
      r4 = cir_pkg::sat32(jx);
      r5 = cir_pkg::sat32(jy);
      odata_in = {r5[31:0], r4[31:0], r3[31:0], r2[31:0], r1[31:0], r0[31:0]};
      ouser_in = {r0[32] | r1[32] | r2[32] | r3[32] | r4[32] | r5[32], h_ff.pres_nz};
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff      <= a_in;
         b_ff      <= b_in;
         c_ff      <= c_in;
         d_ff      <= d_in;
         e_ff      <= e_in;
         pay_ff[0] <= e_ff.p;
         for (int k = 1; k < S; k++) pay_ff[k] <= pay_ff[k-1];
         f_ff      <= f_in;
         g_ff      <= g_in;
         h_ff      <= h_in;
         rsp_tdata <= odata_in;
         rsp_tuser <= ouser_in;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0; vb_ff <= 1'b0; vc_ff <= 1'b0; vd_ff <= 1'b0; ve_ff <= 1'b0;
         vq_ff <= '0;
         vf_ff <= 1'b0; vg_ff <= 1'b0; vh_ff <= 1'b0;
         rsp_tvalid <= 1'b0;
      end else if (adv) begin
         va_ff <= req_tvalid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vq_ff <= {vq_ff[S-2:0], ve_ff};
         vf_ff <= vq_ff[S-1];
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
         rsp_tvalid <= vh_ff;
      end
   end

endmodule

### tb/sv/cir_checker.sv
// Scoreboard for the contact impulse resolver: predicts each result and compares it.
module cir_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [295:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [191:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_wdata,
   output int           errors,
   output int           pending,
   output int           checked,
   output int           clipped
);

   typedef struct {
      logic [31:0] field [6];
      logic        resolved;
      logic        saturated;
   } contact_result_type;

   contact_result_type expected_results [$];

   bit [63:0] slop_q;
   bit [63:0] frac_q;
   bit [63:0] immovable_q;

   // Signed Q1.14 times unsigned magnitude, truncated toward zero
   function automatic longint scale_by_normal(longint n, bit [63:0] m);
      bit [63:0] an;
      bit [63:0] p;
      an = (n < 0) ? 64'(-n) : 64'(n);
      p  = (an * m) >> 14;
      return (n < 0) ? -longint'(p) : longint'(p);
   endfunction

   function automatic logic [31:0] clip32(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic contact_result_type resolve_contact(logic [295:0] d,
                                                          logic [1:0] present);
      contact_result_type r;
      longint    nx, ny, vax, vay, vbx, vby, van;
      longint    res [6];
      bit [63:0] pen, ma, mb, ba, bb, frac, mag, sa, sb, e;
      bit [63:0] imm, mea, meb, mred, vn, u, j;
      logic      dyna, dynb, hasa, hasb, flag;
      nx   = longint'($signed(d[15:0]));
      ny   = longint'($signed(d[31:16]));
      pen  = 64'(d[62:32]);
      ma   = 64'(d[94:63]);
      mb   = 64'(d[126:95]);
      ba   = 64'(d[143:127]);
      bb   = 64'(d[160:144]);
      vax  = longint'($signed(d[192:161]));
      vay  = longint'($signed(d[224:193]));
      vbx  = longint'($signed(d[256:225]));
      vby  = longint'($signed(d[288:257]));
      hasa = present[0];
      hasb = present[1];
      dyna = hasa && ma != 0;
      dynb = hasb && mb != 0;
      flag = 1'b0;
      for (int k = 0; k < 6; k++) res[k] = 0;

      if (present != 2'b00) begin
         // positional correction, split by inverse mass
         frac = (frac_q > 64'(cir_pkg::ONE_Q16)) ? 64'(cir_pkg::ONE_Q16) : frac_q;
         if (pen > slop_q && (dyna || dynb)) begin
            mag = ((pen - slop_q) * frac) >> 16;
            sa = 0;
            sb = 0;
            if (dyna && dynb) begin
               sa = (mag * mb) / (ma + mb);
               sb = (mag * ma) / (ma + mb);
            end else if (dyna) begin
               sa = mag;
            end else begin
               sb = mag;
            end
            if (dyna) begin
               res[0] = -scale_by_normal(nx, sa);
               res[1] = -scale_by_normal(ny, sa);
            end
            if (dynb) begin
               res[2] = scale_by_normal(nx, sb);
               res[3] = scale_by_normal(ny, sb);
            end
         end

         // impulse only while approaching
         if (!hasa) begin
            ba = 0; vax = 0; vay = 0;
         end
         if (!hasb) begin
            bb = 0; vbx = 0; vby = 0;
         end
         if (ba > 64'(cir_pkg::ONE_Q16)) ba = 64'(cir_pkg::ONE_Q16);
         if (bb > 64'(cir_pkg::ONE_Q16)) bb = 64'(cir_pkg::ONE_Q16);
         e   = (ba > bb) ? ba : bb;
         van = (vbx - vax) * nx + (vby - vay) * ny;
         if (van < 0) begin
            imm  = (immovable_q == 0) ? 64'd1 : immovable_q;
            mea  = dyna ? ma : imm;
            meb  = dynb ? mb : imm;
            mred = (mea * meb) / (mea + meb);
            vn   = 64'(-van) >> 14;
            u    = (vn * (64'(cir_pkg::ONE_Q16) + e)) >> 16;
            if (mred != 0 && u > 64'hFFFF_FFFF_FFFF_FFFF / mred) j = 64'(cir_pkg::JMAX);
            else j = (u * mred) >> 16;
            if (j > 64'(cir_pkg::JMAX)) j = 64'(cir_pkg::JMAX);
            res[4] = scale_by_normal(nx, j);
            res[5] = scale_by_normal(ny, j);
         end
      end

      for (int k = 0; k < 6; k++) r.field[k] = clip32(res[k], flag);
      r.resolved  = (present != 2'b00);
      r.saturated = flag;
      return r;
   endfunction

   string field_name [6] = '{"push_a_x", "push_a_y", "push_b_x", "push_b_y",
                             "impulse_x", "impulse_y"};

   assign pending = expected_results.size();

   always @(posedge clock) begin
      contact_result_type want;
      if (reset) begin
         slop_q      <= 64'd655;
         frac_q      <= 64'd52429;
         immovable_q <= 64'd4294967295;
         expected_results.delete();
         errors  <= 0;
         checked <= 0;
         clipped <= 0;
      end else begin
         // register shadow
         if (csr_we) begin
            case (csr_index)
               cir_pkg::CSR_SLOP:      slop_q      <= 64'(csr_wdata[30:0]);
               cir_pkg::CSR_FRACTION:  frac_q      <= 64'(csr_wdata[16:0]);
               cir_pkg::CSR_IMMOVABLE: immovable_q <= 64'(csr_wdata);
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    resolve_contact(req_tdata, req_tuser));
         end
         // compare against oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result item with no prediction waiting");
               errors <= errors + 1;
            end else begin
               int bad;
               want = expected_results.pop_front();
               bad = 0;
               for (int k = 0; k < 6; k++) begin
                  if (rsp_tdata[32*k +: 32] !== want.field[k]) begin
                     $error("%s: expected %0d, got %0d", field_name[k],
                            $signed(want.field[k]), $signed(rsp_tdata[32*k +: 32]));
                     bad++;
                  end
               end
               if (rsp_tuser[0] !== want.resolved) begin
                  $error("resolved: expected %0d, got %0d", want.resolved, rsp_tuser[0]);
                  bad++;
               end
               if (rsp_tuser[1] !== want.saturated) begin
                  $error("saturated: expected %0d, got %0d", want.saturated, rsp_tuser[1]);
                  bad++;
               end
               errors  <= errors + bad;
               checked <= checked + 1;
               if (want.saturated) clipped <= clipped + 1;
            end
         end
      end
   end
endmodule

### tb/sv/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the contact resolver.
module tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // normal_x, normal_y, penetration, mass_a, mass_b, bounce_a, bounce_b,
   // vel_a_x, vel_a_y, vel_b_x, vel_b_y, zero fill
   logic [295:0] req_tdata;
   // bodies_present
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // push_a_x, push_a_y, push_b_x, push_b_y, impulse_x, impulse_y
   logic [191:0] rsp_tdata;
   // resolved, saturated
   logic [1:0]   rsp_tuser;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [31:0]  csr_wdata;

   int errors, pending, checked, clipped;
   int tx_idle, rx_idle;
   int hold_left = 0;
   bit hold_request;
   bit hold_served = 1'b0;
   int cycles = 0;

   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 600000;

   contact_impulse_resolver dut (.*);

   cir_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle budget
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("contact_impulse_resolver regression: fail");
         $finish;
      end
   end

   // result side back-pressure, with one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_served) begin
         hold_served <= 1'b1;
         hold_left   <= 300;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   task automatic send_item(logic [15:0] nx, logic [15:0] ny, logic [30:0] pen,
                            logic [31:0] ma, logic [31:0] mb,
                            logic [16:0] ba, logic [16:0] bb,
                            logic [31:0] vax, logic [31:0] vay,
                            logic [31:0] vbx, logic [31:0] vby, logic [1:0] present);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, vby, vbx, vay, vax, bb, ba, mb, ma, pen, ny, nx};
      req_tuser  <= present;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(cir_pkg::csr_index_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // sender stops until every prediction is matched, then lets the pipe settle
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(32'h0040_0000, 32'h0000_1000);
      endcase
   endfunction

   function automatic logic [31:0] pick_velocity();
      if ($urandom_range(7) == 0) return $urandom;
      return 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
   endfunction

   function automatic logic [16:0] pick_bounce();
      if ($urandom_range(7) == 0) return 17'($urandom);
      return 17'($urandom_range(65536));
   endfunction

   function automatic logic [15:0] pick_normal_part();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'sd16384;
         2: return -16'sd16384;
         default: return 16'($signed($urandom_range(32768)) - 16384);
      endcase
   endfunction

   task automatic random_item;
      logic [30:0] pen;
      if ($urandom_range(7) == 0) pen = 31'($urandom);
      else pen = 31'($urandom_range(32'h0004_0000));
      send_item(pick_normal_part(), pick_normal_part(), pen, pick_mass(), pick_mass(),
                pick_bounce(), pick_bounce(), pick_velocity(), pick_velocity(),
                pick_velocity(), pick_velocity(), 2'($urandom));
   endtask

   task automatic set_regs(logic [31:0] slop_v, logic [31:0] frac_v, logic [31:0] imm_v);
      write_reg(cir_pkg::CSR_SLOP, slop_v);
      write_reg(cir_pkg::CSR_FRACTION, frac_v);
      write_reg(cir_pkg::CSR_IMMOVABLE, imm_v);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      csr_we       = 1'b0;
      csr_index    = cir_pkg::CSR_SLOP;
      csr_wdata    = '0;
      tx_idle      = 0;
      rx_idle      = 0;
      hold_request = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default registers
      send_item(16'sd16384, 16'sd0, 31'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                17'd32768, 17'd0, 32'h0001_0000, 32'd0, -32'sh0001_0000, 32'd0, 2'b11);
      send_item(16'sd0, -16'sd16384, 31'h0000_0100, 32'h0001_0000, 32'h0001_0000,
                17'd0, 17'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 2'b11);
      send_item(16'sd16384, 16'sd0, 31'h0002_0000, 32'd0, 32'h0001_0000,
                17'd65536, 17'd131071, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b11);
      send_item(16'sd16384, 16'sd0, 31'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                17'd65536, 17'd65536, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b01);
      send_item(16'sd16384, 16'sd0, 31'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                17'd65536, 17'd65536, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b10);
      send_item(16'sd16384, 16'sd16384, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                17'd131071, 17'd131071, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 2'b00);
      send_item(-16'sd32768, -16'sd32768, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                17'd65536, 17'd0, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'b11);
      send_item(16'sd32767, 16'sd32767, 31'h7FFF_FFFF, 32'd0, 32'd0,
                17'd0, 17'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 2'b11);
      send_item(-16'sd16384, 16'sd0, 31'd655, 32'h0001_0000, 32'h0001_0000,
                17'd0, 17'd0, -32'sh0001_0000, 32'd0, 32'h0001_0000, 32'd0, 2'b11);
      send_item(16'sd11585, 16'sd11585, 31'd656, 32'h0003_0000, 32'h0001_0000,
                17'd100, 17'd200, 32'd0, 32'd0, 32'd0, 32'd0, 2'b11);
      drain();

      // extremes of the registers
      set_regs(32'd0, 32'd65536, 32'd1);
      send_item(16'sd16384, 16'sd0, 31'd1, 32'h0001_0000, 32'd0,
                17'd0, 17'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b01);
      send_item(16'sd16384, 16'sd0, 31'd0, 32'h0001_0000, 32'h0001_0000,
                17'd0, 17'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b11);
      drain();
      set_regs(32'hFFFF_FFFF, 32'd0, 32'd0);
      send_item(16'sd16384, 16'sd0, 31'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000,
                17'd0, 17'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b11);
      send_item(16'sd16384, 16'sd0, 31'h0001_0000, 32'd0, 32'd0,
                17'd0, 17'd0, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 2'b11);
      drain();
      set_regs(32'd0, 32'h0001_FFFF, 32'hFFFF_FFFF);
      send_item(16'sd16384, -16'sd16384, 31'h7FFF_FFFF, 32'h0001_0000, 32'h0002_0000,
                17'd0, 17'd0, 32'd0, 32'd0, 32'd0, 32'd0, 2'b11);
      drain();

      // random phases: sender heavy, receiver heavy, then full rate
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_regs(32'd655, 32'd52429, 32'hFFFF_FFFF);
            1: set_regs($urandom, $urandom, $urandom);
            2: set_regs($urandom_range(32'h0002_0000), $urandom_range(65536),
                        $urandom_range(32'h0100_0000, 1));
            3: set_regs(32'd0, 32'd65536, 32'hFFFF_FFFF);
            default: set_regs($urandom_range(32'h0001_0000), $urandom_range(131071),
                              $urandom);
         endcase
         tx_idle = (phase == 0) ? 30 : (phase == 1) ? 84 : 0;
         rx_idle = (phase == 0) ? 84 : (phase == 1) ? 30 : 0;
         for (int n = 0; n < 300; n++) begin
            if (phase == 2 && n == 50) hold_request = 1'b1;
            random_item();
         end
         drain();
      end

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d contact pairs over directed cases and five register settings",
               checked);
      $display("%0d results clipped to range, %0d mismatches", clipped, errors);
      if (errors == 0 && pending == 0) begin
         $display("contact_impulse_resolver regression: pass");
      end else begin
         $display("contact_impulse_resolver regression: fail");
      end
      $finish;
   end
endmodule
